>>> src/khld_pkg.sv
// Shared types and constants for the keypad hysteresis and LED dimmer block.
// Used by the configuration registers, the key store and the top level.
package khld_pkg;

    localparam int KEY_W       = 6;
    localparam int LEVEL_W     = 13;
    localparam int CFG_W       = 12;
    localparam int ADDR_BITS   = 3;
    localparam int DEF_NUM_KEYS = 37;

    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 12'd2048;
    localparam logic [CFG_W-1:0] MARGIN_RESET    = 12'd150;

    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_SET     = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;
    localparam logic [1:0] OP_FRAME   = 2'd3;

    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_LED     = 2'd2;

    localparam logic [1:0] BRIGHT_OFF    = 2'd0;
    localparam logic [1:0] BRIGHT_DIM    = 2'd1;
    localparam logic [1:0] BRIGHT_NORMAL = 2'd2;
    localparam logic [1:0] BRIGHT_BRIGHT = 2'd3;

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_MARGIN    = 1'b1;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [KEY_W-1:0]   key_index;
        logic [LEVEL_W-1:0] level;
        logic [1:0]         brightness_code;
    } req_item_t;

    typedef struct packed {
        logic [1:0]       result_kind;
        logic [KEY_W-1:0] event_key;
        logic             column_level;
    } rsp_item_t;

    typedef struct packed {
        logic       pressed;
        logic [1:0] bright;
    } key_entry_t;

    localparam key_entry_t ENTRY_RESET = '{pressed: 1'b0, bright: BRIGHT_DIM};

    typedef struct packed {
        logic             en;
        logic [KEY_W-1:0] addr;
    } mem_rd_t;

    typedef struct packed {
        logic             en;
        logic [KEY_W-1:0] addr;
        key_entry_t       data;
    } mem_wr_t;

endpackage

>>> src/khld_cfg.sv
// APB configuration registers: press threshold and release margin.
// Depends on khld_pkg; provides the release level as a 13-bit sum.
module khld_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [khld_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output logic [khld_pkg::CFG_W-1:0]       threshold,
    output logic [khld_pkg::LEVEL_W-1:0]     release_level
);
    import khld_pkg::*;

    logic [CFG_W-1:0] threshold_reg;
    logic [CFG_W-1:0] margin_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            margin_reg    <= MARGIN_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_THRESHOLD)
                threshold_reg <= pwdata[CFG_W-1:0];
            else
                margin_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_THRESHOLD)
            prdata = {{(32-CFG_W){1'b0}}, threshold_reg};
        else
            prdata = {{(32-CFG_W){1'b0}}, margin_reg};
    end

    assign threshold     = threshold_reg;
    // The sum is one bit wider than either register, so it never wraps.
    assign release_level = {1'b0, threshold_reg} + {1'b0, margin_reg};

endmodule

>>> src/khld_store.sv
// Per-key state memory (pressed bit and brightness) with registered reads.
// Depends on khld_pkg; valid bits stand in for the reset value, and the
// last write is forwarded to a read that overlaps it.
module khld_store #(
    parameter int NUM_KEYS = khld_pkg::DEF_NUM_KEYS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  khld_pkg::mem_rd_t    rd,
    input  khld_pkg::mem_wr_t    wr,
    output khld_pkg::key_entry_t rd_entry
);
    import khld_pkg::*;

    localparam int ADDR_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    key_entry_t        mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] valid_reg;
    key_entry_t        rd_data_reg;
    logic              rd_valid_reg;
    logic [KEY_W-1:0]  rd_addr_reg;
    logic              fwd_valid_reg;
    logic [KEY_W-1:0]  fwd_addr_reg;
    key_entry_t        fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr[ADDR_W-1:0]] <= wr.data;
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr[ADDR_W-1:0]];
            rd_addr_reg <= rd.addr;
        end
        if (wr.en)
        begin
            fwd_addr_reg <= wr.addr;
            fwd_data_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr[ADDR_W-1:0]] <= 1'b1;
                fwd_valid_reg                  <= 1'b1;
            end
            if (rd.en)
                rd_valid_reg <= valid_reg[rd.addr[ADDR_W-1:0]];
        end
    end

    // The forward register always holds the newest write, so a matching
    // address is never stale even when the read came after that write.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg))
            rd_entry = fwd_data_reg;
        else if (rd_valid_reg)
            rd_entry = rd_data_reg;
        else
            rd_entry = ENTRY_RESET;
    end

endmodule

>>> src/keypad_hysteresis_led_dimmer.sv
// Top level of the keypad hysteresis detector with LED dimming.
// Depends on khld_pkg, khld_cfg and khld_store.
//
// The block accepts one item per clock cycle while req_stall is low. An item is
// accepted, its key's entry is read from the key store, and in the next cycle
// the compare or LED lookup runs; the write-back and the load of the output
// register happen at the same edge, as the item leaves the working stage. The
// output register lets a new item enter while a result waits; req_stall rises
// only when the item in the working stage has a result and the output register
// is still held. A write followed at once by a read of the same key is served
// from a forward register. After reset every key reads as released and dim
// without any clearing pass. Configuration is written over APB at byte
// addresses 0 (press threshold) and 4 (release margin).
module keypad_hysteresis_led_dimmer #(
    parameter int NUM_KEYS = khld_pkg::DEF_NUM_KEYS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  khld_pkg::req_item_t            req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output khld_pkg::rsp_item_t            rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [khld_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import khld_pkg::*;

    logic [CFG_W-1:0]   threshold;
    logic [LEVEL_W-1:0] release_level;
    mem_rd_t            rd;
    mem_wr_t            wr;
    key_entry_t         entry;

    logic        req_accept;
    logic        req_in_range;
    logic        s1_valid_reg;
    req_item_t   s1_item_reg;
    logic        s1_in_range_reg;
    logic        s1_emit;
    logic        s1_advance;
    rsp_item_t   s1_rsp;
    key_entry_t  s1_new_entry;
    logic        s1_write;
    logic        lit_n;
    logic [2:0]  phase_reg;
    logic        rsp_valid_reg;
    rsp_item_t   rsp_reg;

    khld_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .threshold     (threshold),
        .release_level (release_level)
    );

    khld_store #(
        .NUM_KEYS (NUM_KEYS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd       (rd),
        .wr       (wr),
        .rd_entry (entry)
    );

    assign req_in_range = {1'b0, req.key_index} < 7'(NUM_KEYS);
    assign req_accept   = req_valid && !req_stall;
    assign req_stall    = s1_valid_reg && !s1_advance;
    assign rd.en        = req_accept && req_in_range;
    assign rd.addr      = req.key_index;

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_item_reg     <= req;
            s1_in_range_reg <= req_in_range;
        end
    end

    // LED drive is active low: a pressed key is lit whatever its brightness.
    always_comb
    begin
        case (entry.bright)
            BRIGHT_BRIGHT: lit_n = 1'b0;
            BRIGHT_NORMAL: lit_n = phase_reg[0];
            BRIGHT_DIM:    lit_n = (phase_reg != 3'd0);
            default:       lit_n = 1'b1;
        endcase
        if (entry.pressed)
            lit_n = 1'b0;
        if (!s1_in_range_reg)
            lit_n = 1'b1;
    end

    always_comb
    begin
        s1_emit          = 1'b0;
        s1_write         = 1'b0;
        s1_new_entry     = entry;
        s1_rsp.result_kind  = KIND_LED;
        s1_rsp.event_key    = s1_item_reg.key_index;
        s1_rsp.column_level = 1'b0;
        case (s1_item_reg.opcode)
            OP_SAMPLE:
            begin
                if (s1_in_range_reg)
                begin
                    if (!entry.pressed && (s1_item_reg.level <= {1'b0, threshold}))
                    begin
                        s1_emit              = 1'b1;
                        s1_write             = 1'b1;
                        s1_new_entry.pressed = 1'b1;
                        s1_rsp.result_kind   = KIND_PRESS;
                    end
                    else if (entry.pressed && (s1_item_reg.level >= release_level))
                    begin
                        s1_emit              = 1'b1;
                        s1_write             = 1'b1;
                        s1_new_entry.pressed = 1'b0;
                        s1_rsp.result_kind   = KIND_RELEASE;
                    end
                end
            end
            OP_SET:
            begin
                s1_write            = s1_in_range_reg;
                s1_new_entry.bright = s1_item_reg.brightness_code;
            end
            OP_QUERY:
            begin
                s1_emit             = 1'b1;
                s1_rsp.column_level = lit_n;
            end
            default:
            begin
            end
        endcase
    end

    assign s1_advance = s1_valid_reg && (!s1_emit || !rsp_valid_reg || !rsp_stall);
    assign wr.en      = s1_advance && s1_write;
    assign wr.addr    = s1_item_reg.key_index;
    assign wr.data    = s1_new_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            phase_reg     <= 3'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_advance)
                s1_valid_reg <= 1'b0;
            if (s1_advance && (s1_item_reg.opcode == OP_FRAME))
                phase_reg <= phase_reg + 3'd1;
            if (s1_advance && s1_emit)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_emit)
            rsp_reg <= s1_rsp;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> src/khld_checker.sv
// Port-level checks for the keypad hysteresis and LED dimmer block.
// Depends on khld_pkg; bound to the top level below.
module khld_checker #(
    parameter int NUM_KEYS = khld_pkg::DEF_NUM_KEYS
) (
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input khld_pkg::rsp_item_t rsp
);
    import khld_pkg::*;

    // A stalled result item keeps its value until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result item changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.result_kind == KIND_PRESS) || (rsp.result_kind == KIND_RELEASE)
                      || (rsp.result_kind == KIND_LED))
    else $error("unknown result kind");

    // Events carry a fixed zero column level.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.result_kind != KIND_LED) |-> !rsp.column_level)
    else $error("event with nonzero column level");

    // Keys outside the matrix never produce press or release events.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.result_kind != KIND_LED)
            |-> ({1'b0, rsp.event_key} < 7'(NUM_KEYS)))
    else $error("event for a key outside the matrix");

endmodule

bind keypad_hysteresis_led_dimmer khld_checker #(
    .NUM_KEYS (NUM_KEYS)
) u_khld_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

>>> tb/tb_keypad_hysteresis_led_dimmer.sv
// Self-checking testbench for keypad_hysteresis_led_dimmer: press/release
// hysteresis, per-key LED brightness and frame phase, checked item by item.
// Depends on khld_pkg and the keypad_hysteresis_led_dimmer RTL only.

import khld_pkg::*;

// Tracks the key table, frame phase and thresholds, and queues the results
// the block owes for the items it has taken in.
class keypad_mirror;
    logic [CFG_W-1:0] threshold;
    logic [CFG_W-1:0] margin;
    bit               pressed[DEF_NUM_KEYS];
    logic [1:0]       shade[DEF_NUM_KEYS];
    logic [2:0]       phase;
    rsp_item_t        owed_results[$];
    int               errors;
    int               taken;
    int               presses;
    int               releases;
    int               led_reads;

    function new();
        threshold = THRESHOLD_RESET;
        margin    = MARGIN_RESET;
        phase     = 3'd0;
        for (int k = 0; k < DEF_NUM_KEYS; k++)
        begin
            pressed[k] = 1'b0;
            shade[k]   = BRIGHT_DIM;
        end
    endfunction

    function void write_register(input logic index, input logic [CFG_W-1:0] value);
        if (index == REG_THRESHOLD)
            threshold = value;
        else
            margin = value;
    endfunction

    // Active-low LED level: 0 means lit.
    function logic led_dark(input int key);
        if (key >= DEF_NUM_KEYS)
            return 1'b1;
        if (pressed[key])
            return 1'b0;
        case (shade[key])
            BRIGHT_BRIGHT: return 1'b0;
            BRIGHT_NORMAL: return phase[0];
            BRIGHT_DIM:    return (phase != 3'd0);
            default:       return 1'b1;
        endcase
    endfunction

    function void absorb_item(input req_item_t item);
        rsp_item_t owed;
        int        key;
        key = item.key_index;
        taken++;
        owed.event_key    = item.key_index;
        owed.column_level = 1'b0;
        case (item.opcode)
            OP_SAMPLE:
            begin
                if (key < DEF_NUM_KEYS)
                begin
                    if (!pressed[key] && int'(item.level) <= int'(threshold))
                    begin
                        pressed[key] = 1'b1;
                        owed.result_kind = KIND_PRESS;
                        owed_results.push_back(owed);
                        presses++;
                    end
                    else if (pressed[key] &&
                             int'(item.level) >= int'(threshold) + int'(margin))
                    begin
                        pressed[key] = 1'b0;
                        owed.result_kind = KIND_RELEASE;
                        owed_results.push_back(owed);
                        releases++;
                    end
                end
            end
            OP_SET:
            begin
                if (key < DEF_NUM_KEYS)
                    shade[key] = item.brightness_code;
            end
            OP_QUERY:
            begin
                owed.result_kind  = KIND_LED;
                owed.column_level = led_dark(key);
                owed_results.push_back(owed);
                led_reads++;
            end
            default:
                phase = phase + 3'd1;
        endcase
    endfunction

    function void match_result(input rsp_item_t got);
        rsp_item_t want;
        if (owed_results.size() == 0)
        begin
            $display("%0t: unexpected result kind=%0d key=%0d column=%0d",
                     $time, got.result_kind, got.event_key, got.column_level);
            errors++;
            return;
        end
        want = owed_results.pop_front();
        if (got.result_kind !== want.result_kind)
        begin
            $display("%0t: result_kind mismatch, expected %0d, actual %0d",
                     $time, want.result_kind, got.result_kind);
            errors++;
        end
        if (got.event_key !== want.event_key)
        begin
            $display("%0t: event_key mismatch, expected %0d, actual %0d",
                     $time, want.event_key, got.event_key);
            errors++;
        end
        if (got.column_level !== want.column_level)
        begin
            $display("%0t: column_level mismatch (key %0d), expected %0d, actual %0d",
                     $time, want.event_key, want.column_level, got.column_level);
            errors++;
        end
    endfunction
endclass

module tb_keypad_hysteresis_led_dimmer;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    req_item_t            req;
    logic                 rsp_valid;
    logic                 rsp_stall;
    rsp_item_t            rsp;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    keypad_mirror mirror = new();

    // Idling controls for the sender and the receiver.
    bit idle_on = 1'b1;
    int gap_odds = 4;
    bit hold_request = 1'b0;
    bit hold_active = 1'b0;
    int settings_used = 0;

    keypad_hysteresis_led_dimmer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                mirror.match_result(rsp);
            if (req_valid && !req_stall)
                mirror.absorb_item(req);
        end
    end

    // Receiver: random stall bursts, calm stretches, and one long hold on request.
    initial
    begin
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_active  = 1'b1;
                rsp_stall <= 1'b1;
                repeat (80) @(posedge clk);
                rsp_stall <= 1'b0;
                hold_active = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 15) == 0)
                repeat ($urandom_range(20, 60)) @(posedge clk);
        end
    end

    function automatic req_item_t make_item(input logic [1:0] op, input int key,
                                            input int level, input logic [1:0] code);
        req_item_t item;
        item.opcode          = op;
        item.key_index       = key[KEY_W-1:0];
        item.level           = level[LEVEL_W-1:0];
        item.brightness_code = code;
        return item;
    endfunction

    // Levels cluster around both switching points so hysteresis gets exercised.
    function automatic req_item_t pick_item();
        int   pick;
        int   key;
        int   level;
        logic [1:0] op;
        pick = $urandom_range(0, 19);
        if (pick < 10)
            op = OP_SAMPLE;
        else if (pick < 13)
            op = OP_SET;
        else if (pick < 18)
            op = OP_QUERY;
        else
            op = OP_FRAME;
        if ($urandom_range(0, 9) == 0)
            key = $urandom_range(0, 63);
        else
            key = $urandom_range(0, DEF_NUM_KEYS - 1);
        case ($urandom_range(0, 9))
            0, 1, 2: level = int'(mirror.threshold) + $urandom_range(0, 4) - 2;
            3, 4, 5: level = int'(mirror.threshold) + int'(mirror.margin)
                             + $urandom_range(0, 4) - 2;
            6:       level = $urandom_range(0, 1) * 4096;
            7, 8:    level = $urandom_range(0, 4096);
            default: level = $urandom_range(0, 8191);
        endcase
        if (level < 0)
            level = 0;
        if (level > 8191)
            level = 8191;
        return make_item(op, key, level, 2'($urandom_range(0, 3)));
    endfunction

    task automatic drive_item(input req_item_t item);
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Holds the sender until every owed result is back, and then waits on for
    // items that produce nothing but may still be in the pipeline.
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (mirror.owed_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic index, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {index, 2'b00};
        pwdata  <= {20'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mirror.write_register(index, value);
        @(posedge clk);
    endtask

    task automatic retune(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] mar);
        settle();
        apb_write(REG_THRESHOLD, thr);
        apb_write(REG_MARGIN, mar);
        settings_used++;
    endtask

    initial
    begin
        logic [CFG_W-1:0] thr_plan[7];
        logic [CFG_W-1:0] mar_plan[7];
        thr_plan = '{12'd0, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd1500};
        mar_plan = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd0, 12'd300};
        req_valid = 1'b0;
        req       = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        rst_n     = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        retune(THRESHOLD_RESET, MARGIN_RESET);
        drive_item(make_item(OP_QUERY, 0, 0, BRIGHT_OFF));
        drive_item(make_item(OP_QUERY, 63, 0, BRIGHT_OFF));
        drive_item(make_item(OP_SAMPLE, 36, 0, BRIGHT_OFF));
        drive_item(make_item(OP_SAMPLE, 36, 0, BRIGHT_OFF));
        drive_item(make_item(OP_SAMPLE, 36, 2197, BRIGHT_OFF));
        drive_item(make_item(OP_SAMPLE, 36, 2198, BRIGHT_OFF));
        drive_item(make_item(OP_SAMPLE, 0, 2048, BRIGHT_OFF));
        drive_item(make_item(OP_SAMPLE, 0, 4096, BRIGHT_OFF));
        drive_item(make_item(OP_SAMPLE, 1, 2049, BRIGHT_OFF));
        drive_item(make_item(OP_SAMPLE, 37, 0, BRIGHT_OFF));
        drive_item(make_item(OP_SAMPLE, 63, 0, BRIGHT_OFF));
        drive_item(make_item(OP_SET, 5, 0, BRIGHT_OFF));
        drive_item(make_item(OP_SET, 6, 0, BRIGHT_NORMAL));
        drive_item(make_item(OP_SET, 7, 0, BRIGHT_BRIGHT));
        drive_item(make_item(OP_SET, 40, 0, BRIGHT_BRIGHT));
        drive_item(make_item(OP_QUERY, 5, 0, BRIGHT_OFF));
        drive_item(make_item(OP_QUERY, 6, 0, BRIGHT_OFF));
        drive_item(make_item(OP_QUERY, 40, 0, BRIGHT_OFF));
        drive_item(make_item(OP_FRAME, 63, 8191, BRIGHT_BRIGHT));
        drive_item(make_item(OP_QUERY, 4, 0, BRIGHT_OFF));
        drive_item(make_item(OP_QUERY, 6, 0, BRIGHT_OFF));
        drive_item(make_item(OP_QUERY, 7, 0, BRIGHT_OFF));
        drive_item(make_item(OP_SAMPLE, 5, 8191, BRIGHT_OFF));
        drive_item(make_item(OP_SAMPLE, 3, 0, BRIGHT_DIM));
        drive_item(make_item(OP_QUERY, 3, 0, BRIGHT_OFF));

        thr_plan[4] = 12'($urandom_range(0, 4095));
        mar_plan[4] = 12'($urandom_range(0, 4095));
        thr_plan[5] = 12'($urandom_range(0, 4095));
        mar_plan[5] = 12'($urandom_range(0, 400));
        for (int p = 0; p < 7; p++)
        begin
            retune(thr_plan[p], mar_plan[p]);
            if (p == 6)
            begin
                idle_on  = 1'b0;
                gap_odds = 0;
            end
            for (int i = 0; i < 86; i++)
            begin
                if (p != 6 && i % 25 == 0)
                    gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
                if (p == 2 && i == 40)
                begin
                    // Keep offering LED reads while the receiver holds off, so
                    // the output side fills and the input side must stall.
                    req_valid <= 1'b0;
                    hold_request = 1'b1;
                    while (!hold_active)
                        @(posedge clk);
                    gap_odds = 0;
                    for (int q = 0; q < 30; q++)
                        drive_item(make_item(OP_QUERY, $urandom_range(0, 63), 0,
                                             BRIGHT_OFF));
                end
                if (p == 4 && i == 40)
                    settle();
                drive_item(pick_item());
            end
        end

        settle();
        $display("Run covered %0d items under %0d threshold/margin settings.",
                 mirror.taken, settings_used);
        $display("Checked %0d press, %0d release and %0d LED results; %0d errors.",
                 mirror.presses, mirror.releases, mirror.led_reads, mirror.errors);
        if (mirror.errors == 0 && mirror.owed_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
src/khld_pkg.sv
src/khld_cfg.sv
src/khld_store.sv
src/keypad_hysteresis_led_dimmer.sv
src/khld_checker.sv
tb/tb_keypad_hysteresis_led_dimmer.sv
